### hdl/wspd_pkg.sv
// Package for the wake score peak decider.
// Holds the shared field widths, register codes, reset values and slot types.
// No dependencies.
package wspd_pkg;

  // Fixed widths of the interface fields.
  localparam int FIELD_SCORE_W = 16;
  localparam int SAMPLE_W      = 48;
  localparam int VOICE_W       = 16;
  localparam int LOCK_W        = 20;
  localparam int COUNT_W       = 32;
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 20;

  // Default score resolution and the number of window slots.
  localparam int SCORE_BITS_DEF = 16;
  localparam int WIN_DEPTH      = 3;

  // Register reset values.
  localparam int ACCEPT_RST  = 34931;
  localparam int SUPPORT_RST = 22938;
  localparam int LOCKOUT_RST = 28000;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ACCEPT_THR  = 2'd0,
    REG_SUPPORT_THR = 2'd1,
    REG_LOCKOUT_LEN = 2'd2
  } cfg_reg_t;

  // Observation carried with each frame score.
  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic [VOICE_W-1:0]  voice_score;
    logic                voice_flag;
    logic                playback_flag;
  } slot_t;

  // Running peak handed from older to newer cells.
  typedef struct packed {
    logic  found;
    slot_t obs;
  } peak_t;

endpackage

### hdl/wspd_cell.sv
// One window slot of the wake score peak decider.
// Holds a frame score and observation, shifts toward the older neighbor and
// updates the running peak and support. Depends on wspd_pkg.
module wspd_cell import wspd_pkg::*; #(
  parameter int SW = SCORE_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          shift,
  // Contents this slot takes on the next shift.
  input  logic          nb_valid,
  input  logic [SW-1:0] nb_score,
  input  slot_t         nb_obs,
  input  logic [SW-1:0] support_thr,
  // Peak over the older slots.
  input  peak_t         best_in,
  input  logic [SW-1:0] best_score_in,
  // Current contents, read by the older neighbor.
  output logic          slot_valid,
  output logic [SW-1:0] slot_score,
  output slot_t         slot_obs,
  // Peak including this slot, and this slot's support vote.
  output peak_t         best_out,
  output logic [SW-1:0] best_score_out,
  output logic          support_out
);

  logic          valid_r;
  logic [SW-1:0] score_r;
  slot_t         obs_r;
  logic          take;

  // Valid bit shifts with the data and is cleared by reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (shift) begin
      valid_r <= nb_valid;
    end
  end

  // Payload shifts without reset.
  always_ff @(posedge clk) begin
    if (shift) begin
      score_r <= nb_score;
      obs_r   <= nb_obs;
    end
  end

  assign slot_valid = valid_r;
  assign slot_score = score_r;
  assign slot_obs   = obs_r;

  // Decision on the post-shift contents; only a strictly larger score
  // displaces an older peak, so the earliest maximum wins.
  assign take = nb_valid && (!best_in.found || (nb_score > best_score_in));

  always_comb begin
    if (take) begin
      best_out.found = 1'b1;
      best_out.obs   = nb_obs;
      best_score_out = nb_score;
    end else begin
      best_out       = best_in;
      best_score_out = best_score_in;
    end
  end

  assign support_out = nb_valid && (nb_score >= support_thr);

endmodule

### hdl/wake_score_peak_decider_top.sv
// Top level of the wake score peak decider.
// Instantiates a chain of wspd_cell window slots and holds the configuration,
// lockout, counters and result register. Depends on wspd_pkg and wspd_cell.
//
//   Channel  Handshake              Carries
//   in_      in_valid / in_ready    score, frame sample, voice score and flags
//   out_     out_valid / out_ready  event fields, frame, peak and event counts
//   cfg_     cfg_valid / cfg_ready  register index and write data
//
// Each frame is decided in the cycle it is accepted; its result is registered,
// so one frame per cycle is sustained while out_ready is high. The shift of
// the three-cell window and the lockout compare and add set the path of that
// cycle. Reset (synchronous, active low) empties the window and clears the
// lockout and counters. A frame is accepted while the output register is empty
// or being read in the same cycle; cfg_ready is always high.
module wake_score_peak_decider_top import wspd_pkg::*; #(
  parameter int SCORE_BITS = SCORE_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  // Frame input.
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [FIELD_SCORE_W-1:0] in_score,
  input  logic [SAMPLE_W-1:0]      in_frame_sample,
  input  logic [VOICE_W-1:0]       in_voice_score,
  input  logic                     in_voice_active,
  input  logic                     in_playback_on,
  // Result output.
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic                     out_wake_detected,
  output logic [SAMPLE_W-1:0]      out_event_sample,
  output logic [FIELD_SCORE_W-1:0] out_event_score,
  output logic [VOICE_W-1:0]       out_event_voice_score,
  output logic                     out_event_playback,
  output logic [COUNT_W-1:0]       out_frames_seen,
  output logic [FIELD_SCORE_W-1:0] out_highest_score,
  output logic [COUNT_W-1:0]       out_events_seen,
  // Configuration writes.
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [CFG_DATA_W-1:0]    cfg_wdata
);

  // Stored score width: the field width or less.
  localparam int SW = (SCORE_BITS < FIELD_SCORE_W) ? SCORE_BITS : FIELD_SCORE_W;
  localparam logic [COUNT_W-1:0]  COUNT_MAX  = '1;
  localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = '1;

  logic                accept;
  logic                cfg_write;
  cfg_reg_t            cfg_reg;

  logic [SW-1:0]       accept_thr_r;
  logic [SW-1:0]       support_thr_r;
  logic [LOCK_W-1:0]   lockout_len_r;
  logic [SAMPLE_W-1:0] lockout_end_r;
  logic [COUNT_W-1:0]  frame_cnt_r;
  logic [COUNT_W-1:0]  event_cnt_r;
  logic [SW-1:0]       max_score_r;

  logic                out_valid_r;
  logic                wake_r;
  slot_t               event_obs_r;
  logic [SW-1:0]       event_score_r;

  // Window chain: index 0 oldest, index WIN_DEPTH-1 newest.
  logic                nb_valid   [WIN_DEPTH];
  logic [SW-1:0]       nb_score   [WIN_DEPTH];
  slot_t               nb_obs     [WIN_DEPTH];
  logic                slot_valid [WIN_DEPTH];
  logic [SW-1:0]       slot_score [WIN_DEPTH];
  slot_t               slot_obs   [WIN_DEPTH];
  peak_t               best_in    [WIN_DEPTH];
  logic [SW-1:0]       best_sc_in [WIN_DEPTH];
  peak_t               best_out   [WIN_DEPTH];
  logic [SW-1:0]       best_sc_out[WIN_DEPTH];
  logic                support    [WIN_DEPTH];

  slot_t               new_obs;
  peak_t               peak;
  logic [SW-1:0]       peak_score;
  logic                enough_support;
  logic                fire;
  logic [SAMPLE_W:0]   end_sum;
  logic [SW-1:0]       head_score;

  // Handshakes.
  assign in_ready  = !out_valid_r || out_ready;
  assign accept    = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid && cfg_ready;
  assign cfg_reg   = cfg_reg_t'(cfg_index);

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      accept_thr_r  <= SW'(ACCEPT_RST);
      support_thr_r <= SW'(SUPPORT_RST);
      lockout_len_r <= LOCK_W'(LOCKOUT_RST);
    end else if (cfg_write) begin
      unique case (cfg_reg)
        REG_ACCEPT_THR:  accept_thr_r  <= cfg_wdata[SW-1:0];
        REG_SUPPORT_THR: support_thr_r <= cfg_wdata[SW-1:0];
        REG_LOCKOUT_LEN: lockout_len_r <= cfg_wdata[LOCK_W-1:0];
        default: ;
      endcase
    end
  end

  // New frame entering the newest cell.
  assign head_score            = in_score[SW-1:0];
  assign new_obs.sample        = in_frame_sample;
  assign new_obs.voice_score   = in_voice_score;
  assign new_obs.voice_flag    = in_voice_active;
  assign new_obs.playback_flag = in_playback_on;

  // Chain wiring: data flows newest to oldest, the peak oldest to newest.
  genvar g;
  generate
    for (g = 0; g < WIN_DEPTH; g++) begin : g_cell
      if (g == WIN_DEPTH - 1) begin : g_head
        assign nb_valid[g] = 1'b1;
        assign nb_score[g] = head_score;
        assign nb_obs[g]   = new_obs;
      end else begin : g_body
        assign nb_valid[g] = slot_valid[g+1];
        assign nb_score[g] = slot_score[g+1];
        assign nb_obs[g]   = slot_obs[g+1];
      end
      if (g == 0) begin : g_first
        assign best_in[g]    = '0;
        assign best_sc_in[g] = '0;
      end else begin : g_rest
        assign best_in[g]    = best_out[g-1];
        assign best_sc_in[g] = best_sc_out[g-1];
      end

      wspd_cell #(
        .SW (SW)
      ) u_cell (
        .clk            (clk),
        .rst_n          (rst_n),
        .shift          (accept),
        .nb_valid       (nb_valid[g]),
        .nb_score       (nb_score[g]),
        .nb_obs         (nb_obs[g]),
        .support_thr    (support_thr_r),
        .best_in        (best_in[g]),
        .best_score_in  (best_sc_in[g]),
        .slot_valid     (slot_valid[g]),
        .slot_score     (slot_score[g]),
        .slot_obs       (slot_obs[g]),
        .best_out       (best_out[g]),
        .best_score_out (best_sc_out[g]),
        .support_out    (support[g])
      );
    end
  endgenerate

  assign peak       = best_out[WIN_DEPTH-1];
  assign peak_score = best_sc_out[WIN_DEPTH-1];

  // At least two of the three slots vote for support.
  assign enough_support = (support[0] && support[1]) || (support[0] && support[2]) ||
                          (support[1] && support[2]);

  // Wake decision on the shifted window.
  assign fire = peak.found && (peak.obs.sample >= lockout_end_r) &&
                peak.obs.voice_flag && (peak_score >= accept_thr_r) && enough_support;

  // Lockout end, saturating at the largest sample index.
  assign end_sum = {1'b0, peak.obs.sample} + (SAMPLE_W + 1)'(lockout_len_r);

  // Lockout and running counters.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lockout_end_r <= '0;
      frame_cnt_r   <= '0;
      event_cnt_r   <= '0;
      max_score_r   <= '0;
    end else if (accept) begin
      if (frame_cnt_r != COUNT_MAX) begin
        frame_cnt_r <= frame_cnt_r + 1'b1;
      end
      if (head_score > max_score_r) begin
        max_score_r <= head_score;
      end
      if (fire) begin
        if (event_cnt_r != COUNT_MAX) begin
          event_cnt_r <= event_cnt_r + 1'b1;
        end
        lockout_end_r <= end_sum[SAMPLE_W] ? SAMPLE_MAX : end_sum[SAMPLE_W-1:0];
      end
    end
  end

  // Result register valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Event fields, zero when no event.
  always_ff @(posedge clk) begin
    if (accept) begin
      wake_r        <= fire;
      event_obs_r   <= fire ? peak.obs : '0;
      event_score_r <= fire ? peak_score : '0;
    end
  end

  // Counters change only on an accept, which also loads the result register.
  assign out_valid             = out_valid_r;
  assign out_wake_detected     = wake_r;
  assign out_event_sample      = event_obs_r.sample;
  assign out_event_score       = FIELD_SCORE_W'(event_score_r);
  assign out_event_voice_score = event_obs_r.voice_score;
  assign out_event_playback    = event_obs_r.playback_flag;
  assign out_frames_seen       = frame_cnt_r;
  assign out_highest_score     = FIELD_SCORE_W'(max_score_r);
  assign out_events_seen       = event_cnt_r;

  // Every accepted frame leaves a result in the output register.
  a_accept_loads: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid_r)
    else $error("accepted frame left no result");

  // Events never outnumber frames.
  a_events_le_frames: assert property (@(posedge clk) disable iff (!rst_n)
    event_cnt_r <= frame_cnt_r)
    else $error("event count above frame count");

  // A shown event has been counted.
  a_event_counted: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && wake_r) |-> (event_cnt_r != '0))
    else $error("event shown but not counted");

  // Without an event the event fields are zero.
  a_no_event_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !wake_r) |-> ((event_obs_r == '0) && (event_score_r == '0)))
    else $error("event fields set without an event");

  // An event moves the lockout end to at least the peak sample.
  a_lockout_moves: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && fire) |=> (lockout_end_r >= $past(peak.obs.sample)))
    else $error("lockout end below event sample");

endmodule

### tb/wake_score_peak_decider_top_test.sv
// Self-checking testbench for wake_score_peak_decider_top.
// Drives frames and register writes, predicts each decision in SystemVerilog.
// Depends on wspd_pkg and the RTL of the wake score peak decider.
module wake_score_peak_decider_top_test;
  import wspd_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [SAMPLE_W-1:0] SAMPLE_TOP = '1;
  localparam logic [COUNT_W-1:0]  COUNT_TOP  = '1;
  localparam int PHASE_ITEMS = 265;

  // One frame as it is offered on the input channel.
  typedef struct packed {
    logic [FIELD_SCORE_W-1:0] score;
    logic [SAMPLE_W-1:0]      sample;
    logic [VOICE_W-1:0]       voice;
    logic                     voice_on;
    logic                     playback;
  } frame_t;

  // One decision as it leaves the result channel.
  typedef struct packed {
    logic                     wake;
    logic [SAMPLE_W-1:0]      ev_sample;
    logic [FIELD_SCORE_W-1:0] ev_score;
    logic [VOICE_W-1:0]       ev_voice;
    logic                     ev_playback;
    logic [COUNT_W-1:0]       frames;
    logic [FIELD_SCORE_W-1:0] highest;
    logic [COUNT_W-1:0]       events;
  } decision_t;

  // A stimulus row; a typed row carries its decision written out by hand.
  typedef struct {
    frame_t    f;
    bit        typed;
    decision_t want;
  } vector_t;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic [FIELD_SCORE_W-1:0] in_score = '0;
  logic [SAMPLE_W-1:0]      in_frame_sample = '0;
  logic [VOICE_W-1:0]       in_voice_score = '0;
  logic                     in_voice_active = 1'b0;
  logic                     in_playback_on = 1'b0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic                     out_wake_detected;
  logic [SAMPLE_W-1:0]      out_event_sample;
  logic [FIELD_SCORE_W-1:0] out_event_score;
  logic [VOICE_W-1:0]       out_event_voice_score;
  logic                     out_event_playback;
  logic [COUNT_W-1:0]       out_frames_seen;
  logic [FIELD_SCORE_W-1:0] out_highest_score;
  logic [COUNT_W-1:0]       out_events_seen;
  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic [CFG_IDX_W-1:0]     cfg_index = '0;
  logic [CFG_DATA_W-1:0]    cfg_wdata = '0;

  // Shadow copy of the decider: registers, window and counters.
  logic [FIELD_SCORE_W-1:0] acc_thr = FIELD_SCORE_W'(ACCEPT_RST);
  logic [FIELD_SCORE_W-1:0] sup_thr = FIELD_SCORE_W'(SUPPORT_RST);
  logic [LOCK_W-1:0]        lock_len = LOCK_W'(LOCKOUT_RST);
  logic [FIELD_SCORE_W-1:0] win_score [WIN_DEPTH] = '{default: '0};
  slot_t                    win_obs [WIN_DEPTH] = '{default: '0};
  int                       fill_count = 0;
  logic [SAMPLE_W-1:0]      lock_end = '0;
  logic [COUNT_W-1:0]       frame_cnt = '0;
  logic [FIELD_SCORE_W-1:0] top_score = '0;
  logic [COUNT_W-1:0]       event_cnt = '0;

  decision_t           pending_decisions [$];
  vector_t             directed_rows [$];
  vector_t             tail_rows [$];
  logic [SAMPLE_W-1:0] cursor = '0;
  int                  idle_in = 0;
  int                  idle_out = 0;
  int                  errors = 0;

  wake_score_peak_decider_top i_dut (.*);

  // Clock, 10 ns period.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shifts a frame into the window and decides on the earliest peak.
  function automatic decision_t decide_frame(frame_t f);
    decision_t       d;
    int              first;
    int              peak;
    int              support;
    bit              fire;
    logic [SAMPLE_W:0] sum;
    d = '0;
    for (int i = 0; i < WIN_DEPTH - 1; i++) begin
      win_score[i] = win_score[i + 1];
      win_obs[i]   = win_obs[i + 1];
    end
    win_score[WIN_DEPTH-1] = f.score;
    win_obs[WIN_DEPTH-1]   = '{sample: f.sample, voice_score: f.voice,
                               voice_flag: f.voice_on, playback_flag: f.playback};
    if (fill_count < WIN_DEPTH) fill_count++;
    if (frame_cnt != COUNT_TOP) frame_cnt++;
    if (f.score > top_score) top_score = f.score;

    // Only filled slots count; ties keep the oldest slot as the peak.
    first = WIN_DEPTH - fill_count;
    peak = first;
    support = 0;
    for (int i = first; i < WIN_DEPTH; i++) begin
      if (win_score[i] >= sup_thr) support++;
      if (win_score[i] > win_score[peak]) peak = i;
    end
    fire = win_obs[peak].sample >= lock_end && win_obs[peak].voice_flag &&
           win_score[peak] >= acc_thr && support >= 2;

    if (fire) begin
      if (event_cnt != COUNT_TOP) event_cnt++;
      sum = {1'b0, win_obs[peak].sample} + (SAMPLE_W + 1)'(lock_len);
      lock_end = sum[SAMPLE_W] ? SAMPLE_TOP : sum[SAMPLE_W-1:0];
      d.wake        = 1'b1;
      d.ev_sample   = win_obs[peak].sample;
      d.ev_score    = win_score[peak];
      d.ev_voice    = win_obs[peak].voice_score;
      d.ev_playback = win_obs[peak].playback_flag;
    end
    d.frames  = frame_cnt;
    d.highest = top_score;
    d.events  = event_cnt;
    return d;
  endfunction

  function automatic vector_t row(logic [FIELD_SCORE_W-1:0] score,
                                  logic [SAMPLE_W-1:0] sample,
                                  logic [VOICE_W-1:0] voice, logic voice_on,
                                  logic playback);
    vector_t v;
    v.f = '{score: score, sample: sample, voice: voice, voice_on: voice_on,
            playback: playback};
    v.typed = 1'b0;
    v.want = '0;
    return v;
  endfunction

  function automatic vector_t row_want(vector_t v, logic wake,
                                       logic [SAMPLE_W-1:0] ev_sample,
                                       logic [FIELD_SCORE_W-1:0] ev_score,
                                       logic [VOICE_W-1:0] ev_voice,
                                       logic ev_playback,
                                       logic [COUNT_W-1:0] frames,
                                       logic [FIELD_SCORE_W-1:0] highest,
                                       logic [COUNT_W-1:0] events);
    v.typed = 1'b1;
    v.want = '{wake: wake, ev_sample: ev_sample, ev_score: ev_score,
               ev_voice: ev_voice, ev_playback: ev_playback, frames: frames,
               highest: highest, events: events};
    return v;
  endfunction

  // Random score within a few hundred codes of a threshold.
  function automatic logic [FIELD_SCORE_W-1:0] near(int centre);
    int lo;
    int hi;
    lo = (centre < 500) ? 0 : centre - 500;
    hi = (centre > 65035) ? 65535 : centre + 500;
    return FIELD_SCORE_W'($urandom_range(hi, lo));
  endfunction

  // Mostly frames on a rising sample clock; a few noise frames with any
  // sample index and no voice, so they never set the lockout.
  function automatic vector_t next_frame();
    logic [63:0]              wide;
    logic [FIELD_SCORE_W-1:0] score;
    wide = {$urandom, $urandom};
    if ($urandom_range(99) < 8)
      return row(FIELD_SCORE_W'($urandom), wide[SAMPLE_W-1:0], VOICE_W'($urandom),
                 1'b0, 1'($urandom_range(1)));
    cursor = cursor + SAMPLE_W'($urandom_range(3000));
    case ($urandom_range(3))
      0: score = FIELD_SCORE_W'($urandom);
      1: score = near(int'(sup_thr));
      2: score = near(int'(acc_thr));
      default: score = FIELD_SCORE_W'($urandom_range(65535, acc_thr));
    endcase
    return row(score, cursor, VOICE_W'($urandom), $urandom_range(99) < 80,
               1'($urandom_range(1)));
  endfunction

  // Offers one frame, waits for its transaction and records the decision.
  task automatic send_frame(vector_t v);
    decision_t d;
    while ($urandom_range(99) < idle_in) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_score        <= v.f.score;
    in_frame_sample <= v.f.sample;
    in_voice_score  <= v.f.voice;
    in_voice_active <= v.f.voice_on;
    in_playback_on  <= v.f.playback;
    do @(posedge clk); while (!in_ready);
    d = decide_frame(v.f);
    pending_decisions.push_back(v.typed ? v.want : d);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_ACCEPT_THR:  acc_thr = data[FIELD_SCORE_W-1:0];
      REG_SUPPORT_THR: sup_thr = data[FIELD_SCORE_W-1:0];
      REG_LOCKOUT_LEN: lock_len = data[LOCK_W-1:0];
      default: ;
    endcase
  endtask

  // Drains the block, then writes all three registers.
  task automatic apply_setting(int acc, int sup, int lock);
    in_valid <= 1'b0;
    while (pending_decisions.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
    write_reg(REG_ACCEPT_THR, CFG_DATA_W'(acc));
    write_reg(REG_SUPPORT_THR, CFG_DATA_W'(sup));
    write_reg(REG_LOCKOUT_LEN, CFG_DATA_W'(lock));
    cfg_valid <= 1'b0;
  endtask

  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
    end
  endtask

  task automatic check_decision();
    decision_t want;
    if (pending_decisions.size() == 0) begin
      errors++;
      $display("%0t: result transaction with no decision pending", $time);
    end else begin
      want = pending_decisions.pop_front();
      check_field("wake_detected", 64'(want.wake), 64'(out_wake_detected));
      check_field("event_sample", 64'(want.ev_sample), 64'(out_event_sample));
      check_field("event_score", 64'(want.ev_score), 64'(out_event_score));
      check_field("event_voice_score", 64'(want.ev_voice), 64'(out_event_voice_score));
      check_field("event_playback", 64'(want.ev_playback), 64'(out_event_playback));
      check_field("frames_seen", 64'(want.frames), 64'(out_frames_seen));
      check_field("highest_score", 64'(want.highest), 64'(out_highest_score));
      check_field("events_seen", 64'(want.events), 64'(out_events_seen));
    end
  endtask

  // Result side: check each transaction, then stall at random.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) check_decision();
    out_ready <= ($urandom_range(99) >= idle_out);
  end

  // Safety net against a hung handshake.
  initial begin
    #5_000_000;
    $display("wake_score_peak_decider_top verification failed");
    $finish;
  end

  initial begin
    // Hand-built rows: window filling, lockout edge, voice gating, thresholds.
    directed_rows.push_back(row_want(row(0, 0, 0, 0, 0), 0, 0, 0, 0, 0, 1, 0, 0));
    directed_rows.push_back(row_want(row(16'hFFFF, 1000, 16'hFFFF, 1, 1),
                                     0, 0, 0, 0, 0, 2, 16'hFFFF, 0));
    directed_rows.push_back(row_want(row(16'hFFFF, 2000, 1234, 1, 0),
                                     1, 1000, 16'hFFFF, 16'hFFFF, 1, 3, 16'hFFFF, 1));
    directed_rows.push_back(row_want(row(16'hFFFF, 3000, 0, 1, 0),
                                     0, 0, 0, 0, 0, 4, 16'hFFFF, 1));
    directed_rows.push_back(row(40000, 29000, 500, 1, 1));
    directed_rows.push_back(row(30000, 29100, 600, 1, 0));
    directed_rows.push_back(row(10000, 29200, 700, 0, 0));
    directed_rows.push_back(row(60000, 60000, 800, 0, 1));
    directed_rows.push_back(row(50000, 60100, 900, 1, 0));
    directed_rows.push_back(row(50000, 60200, 1000, 1, 1));
    directed_rows.push_back(row(0, 65000, 0, 1, 0));
    directed_rows.push_back(row(0, 65100, 0, 1, 0));
    directed_rows.push_back(row(34930, 70000, 2, 1, 0));
    directed_rows.push_back(row(34931, 70100, 3, 1, 1));
    directed_rows.push_back(row(22938, 100000, 4, 1, 0));
    directed_rows.push_back(row(22937, 100100, 5, 1, 0));
    directed_rows.push_back(row(40000, 100200, 6, 1, 1));
    directed_rows.push_back(row(1, 200000, 16'h8001, 1, 0));
    // Samples at the top of the range drive the lockout end into saturation.
    tail_rows.push_back(row(16'hFFFF, SAMPLE_TOP - 30, 7, 1, 0));
    tail_rows.push_back(row(16'hFFFF, SAMPLE_TOP - 20, 8, 1, 1));
    tail_rows.push_back(row(16'hFFFF, SAMPLE_TOP, 9, 1, 0));
    tail_rows.push_back(row(100, SAMPLE_TOP, 10, 1, 1));
    tail_rows.push_back(row(100, SAMPLE_TOP, 11, 1, 0));
    tail_rows.push_back(row(100, SAMPLE_TOP, 12, 1, 1));

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) send_frame(directed_rows[i]);

    // Random phases: receiver stalls most first, then the sender idles most, then neither.
    for (int p = 0; p < 6; p++) begin
      idle_in  = (p < 2) ? 30 : (p < 4) ? 67 : 0;
      idle_out = (p < 2) ? 67 : (p < 4) ? 30 : 0;
      case (p)
        0: apply_setting(ACCEPT_RST, SUPPORT_RST, LOCKOUT_RST);
        1: apply_setting(1, 0, 0);
        2: apply_setting(65535, 65535, 1048575);
        3: apply_setting(40000, 20000, 5000);
        4: apply_setting($urandom_range(65535, 1), $urandom_range(65535),
                         $urandom_range(1048575));
        default: apply_setting(30000, 30000, 100000);
      endcase
      cursor = lock_end + SAMPLE_W'({$urandom_range(4095), $urandom});
      repeat (PHASE_ITEMS) send_frame(next_frame());
    end

    apply_setting(1, 0, 1048575);
    foreach (tail_rows[i]) send_frame(tail_rows[i]);

    in_valid <= 1'b0;
    while (pending_decisions.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (errors == 0)
      $display("wake_score_peak_decider_top verification clean");
    else
      $display("wake_score_peak_decider_top verification failed");
    $finish;
  end

endmodule
